// ----- hdl/sms_pkg.sv -----
// Shared widths and constants for the sample mean / standard deviation core.
// No dependencies; used by sample_mean_stddev_core.
`timescale 1ns / 1ps
`default_nettype none

package sms_pkg;

   // Port field widths
   localparam int IN_W  = 16;
   localparam int OUT_W = 24;
   localparam int CNT_W = 12;

   // Count register reset value and lower clamp
   localparam logic [CNT_W-1:0] COUNT_RESET = 12'd200;
   localparam logic [CNT_W-1:0] MIN_COUNT   = 12'd10;

   // Shared datapath widths, sized for the widest sample
   localparam int ACC_W = 58;   // accumulator / remainder
   localparam int MPL_W = 28;   // multiplier operand (widest running sum)
   localparam int DEV_W = 56;   // n*Q - S*S
   localparam int DEN_W = 24;   // n*(n-1)
   localparam int QUO_W = 64;   // quotient / root
   localparam int DVD_W = 72;   // dividend shift register
   localparam int STEP_W = 7;   // step counter

   // Step counts of each sequencer phase
   localparam int MD_STEPS   = CNT_W;          // n*(n-1)
   localparam int DIVM_STEPS = MPL_W + 8;      // (S << 8) / n
   localparam int MNQ_STEPS  = CNT_W;          // n*Q
   localparam int MSS_STEPS  = MPL_W;          // subtract S*S
   localparam int DIVV_STEPS = DEV_W + 16;     // (dev << 16) / den
   localparam int SQRT_STEPS = QUO_W / 2;      // one root bit per step

endpackage

`default_nettype wire

// ----- hdl/sample_mean_stddev_core.sv -----
// Sample mean and sample standard deviation core, Q8 fixed point outputs.
// Depends on sms_pkg (widths, constants, step counts).
`timescale 1ns / 1ps
`default_nettype none

// Channel  Ports                                 Handshake
// -------  ------------------------------------  ---------------------
// req      req_valid req_ready req_sample        valid/ready
// rsp      rsp_valid rsp_ready rsp_mean_q8,      valid/ready
//          rsp_stddev_q8
// csr      csr_wr_en csr_wr_data                 write on enable, no wait
//
// A warm-up word or a non-final sample is taken while ready stays high.
// The final sample of a run starts the shared add/subtract unit through n*(n-1),
// (S << 8) / n, n*Q, minus S*S, (dev << 16) / den and the root, then loads the
// result, with req_ready low throughout. The result waits in an output register;
// if it is still untaken when the next result is ready, the sequencer holds.
// Reset is synchronous and restores the count register to 200.

module sample_mean_stddev_core #(
   parameter int MAX_COUNT   = 4095,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [sms_pkg::IN_W-1:0]    req_sample,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [sms_pkg::OUT_W-1:0]   rsp_mean_q8,
   output logic [sms_pkg::OUT_W-1:0]   rsp_stddev_q8,
   input  logic                        csr_wr_en,
   input  logic [sms_pkg::CNT_W-1:0]   csr_wr_data
);

   localparam int CW    = sms_pkg::CNT_W;
   localparam int AW    = sms_pkg::ACC_W;
   localparam int MW    = sms_pkg::MPL_W;
   localparam int QW    = sms_pkg::QUO_W;
   localparam int DW    = sms_pkg::DVD_W;
   localparam int NW    = sms_pkg::DEN_W;
   localparam int VW    = sms_pkg::DEV_W;
   localparam int OW    = sms_pkg::OUT_W;
   localparam int SW    = sms_pkg::STEP_W;
   localparam int SUM_W = SAMPLE_BITS + CW;
   localparam int SQ_W  = 2 * SAMPLE_BITS + CW;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_MD   = 3'd1;
   localparam logic [2:0] ST_DIVM = 3'd2;
   localparam logic [2:0] ST_MNQ  = 3'd3;
   localparam logic [2:0] ST_MSS  = 3'd4;
   localparam logic [2:0] ST_DIVV = 3'd5;
   localparam logic [2:0] ST_SQRT = 3'd6;
   localparam logic [2:0] ST_DONE = 3'd7;

   // Registers and next values
   logic [2:0]         state_ff, state_in;
   logic               warm_ff, warm_in;
   logic [CW-1:0]      taken_ff, taken_in;
   logic [SUM_W-1:0]   sum_ff, sum_in;
   logic [SQ_W-1:0]    sq_ff, sq_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [CW-1:0]      n_ff, n_in;
   logic [NW-1:0]      den_ff, den_in;
   logic [AW-1:0]      acc_ff, acc_in;
   logic [AW-1:0]      mcand_ff, mcand_in;
   logic [MW-1:0]      mpl_ff, mpl_in;
   logic [DW-1:0]      dvd_ff, dvd_in;
   logic [QW-1:0]      quo_ff, quo_in;
   logic [SW-1:0]      cnt_ff, cnt_in;
   logic [OW-1:0]      mean_ff, mean_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [OW-1:0]      rsp_mean_ff, rsp_mean_in;
   logic [OW-1:0]      rsp_sd_ff, rsp_sd_in;

   // Sample path
   logic [CW-1:0]            k_eff;
   logic [SAMPLE_BITS-1:0]   smp;
   logic [2*SAMPLE_BITS-1:0] smp_sq;
   logic [SUM_W-1:0]         sum_add;
   logic [SQ_W-1:0]          sq_add;
   logic [CW-1:0]            taken_inc;
   logic                     last_sample;
   logic                     req_fire;

   // Shared unit
   logic [AW-1:0] opa, opb;
   logic          op_sub;
   logic [AW:0]   alu_sum;
   logic [AW-1:0] alu_res;
   logic          alu_carry;
   logic          step_last;
   logic [QW-1:0] quo_step;
   logic [AW-1:0] acc_step;

   // Clamp the run length
   always_comb begin
      k_eff = count_ff;
      priority if (count_ff < sms_pkg::MIN_COUNT) begin
         k_eff = sms_pkg::MIN_COUNT;
      end else if (32'(count_ff) > MAX_COUNT) begin
         k_eff = CW'(MAX_COUNT);
      end else begin
         k_eff = count_ff;
      end
   end

   // Square and accumulate the incoming sample
   assign smp         = req_sample[SAMPLE_BITS-1:0];
   assign smp_sq      = smp * smp;
   assign sum_add     = sum_ff + SUM_W'(smp);
   assign sq_add      = sq_ff + SQ_W'(smp_sq);
   assign taken_inc   = taken_ff + 1'b1;
   assign last_sample = (taken_inc >= k_eff);
   assign req_ready   = (state_ff == ST_IDLE);
   assign req_fire    = req_valid && req_ready;

   // Select operands of the shared add/subtract unit
   always_comb begin
      opa    = acc_ff;
      opb    = '0;
      op_sub = 1'b0;
      unique case (state_ff)
         ST_MD, ST_MNQ: begin
            opb = mpl_ff[0] ? mcand_ff : '0;
         end
         ST_MSS: begin
            opb    = mpl_ff[0] ? mcand_ff : '0;
            op_sub = 1'b1;
         end
         ST_DIVM: begin
            opa    = {acc_ff[AW-2:0], dvd_ff[DW-1]};
            opb    = AW'(n_ff);
            op_sub = 1'b1;
         end
         ST_DIVV: begin
            opa    = {acc_ff[AW-2:0], dvd_ff[DW-1]};
            opb    = AW'(den_ff);
            op_sub = 1'b1;
         end
         ST_SQRT: begin
            opa    = {acc_ff[AW-3:0], dvd_ff[DW-1:DW-2]};
            opb    = {quo_ff[AW-3:0], 2'b01};
            op_sub = 1'b1;
         end
         ST_IDLE, ST_DONE: begin
            opb = '0;
         end
      endcase
   end

   assign alu_sum   = {1'b0, opa} + {1'b0, (op_sub ? ~opb : opb)} + {{AW{1'b0}}, op_sub};
   assign alu_res   = alu_sum[AW-1:0];
   assign alu_carry = alu_sum[AW];
   assign step_last = (cnt_ff == SW'(1));

   // Restoring step shared by both divisions and the root
   assign acc_step  = alu_carry ? alu_res : opa;
   assign quo_step  = {quo_ff[QW-2:0], alu_carry};

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      warm_in      = warm_ff;
      taken_in     = taken_ff;
      sum_in       = sum_ff;
      sq_in        = sq_ff;
      count_in     = csr_wr_en ? csr_wr_data : count_ff;
      n_in         = n_ff;
      den_in       = den_ff;
      acc_in       = acc_ff;
      mcand_in     = mcand_ff;
      mpl_in       = mpl_ff;
      dvd_in       = dvd_ff;
      quo_in       = quo_ff;
      cnt_in       = cnt_ff;
      mean_in      = mean_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_mean_in  = rsp_mean_ff;
      rsp_sd_in    = rsp_sd_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (!warm_ff) begin
                  // drop the warm-up word
                  warm_in = 1'b1;
               end else begin
                  sum_in   = sum_add;
                  sq_in    = sq_add;
                  taken_in = taken_inc;
                  if (last_sample) begin
                     // start n*(n-1)
                     n_in     = taken_inc;
                     acc_in   = '0;
                     mcand_in = AW'(taken_inc - 1'b1);
                     mpl_in   = MW'(taken_inc);
                     cnt_in   = SW'(sms_pkg::MD_STEPS);
                     state_in = ST_MD;
                  end
               end
            end
         end
         ST_MD, ST_MNQ, ST_MSS: begin
            // shift-add multiply (shift-subtract in ST_MSS), one multiplier bit a step
            acc_in   = alu_res;
            mcand_in = {mcand_ff[AW-2:0], 1'b0};
            mpl_in   = {1'b0, mpl_ff[MW-1:1]};
            cnt_in   = cnt_ff - 1'b1;
            if (step_last) begin
               priority if (state_ff == ST_MD) begin
                  // den done; start (S << 8) / n
                  den_in   = alu_res[NW-1:0];
                  acc_in   = '0;
                  quo_in   = '0;
                  dvd_in   = {MW'(sum_ff), 8'b0, {(DW - MW - 8){1'b0}}};
                  cnt_in   = SW'(sms_pkg::DIVM_STEPS);
                  state_in = ST_DIVM;
               end else if (state_ff == ST_MNQ) begin
                  // n*Q done; subtract S*S from it
                  mcand_in = AW'(sum_ff);
                  mpl_in   = MW'(sum_ff);
                  cnt_in   = SW'(sms_pkg::MSS_STEPS);
                  state_in = ST_MSS;
               end else begin
                  // deviation done; start (dev << 16) / den
                  dvd_in   = {alu_res[VW-1:0], {(DW - VW){1'b0}}};
                  acc_in   = '0;
                  quo_in   = '0;
                  cnt_in   = SW'(sms_pkg::DIVV_STEPS);
                  state_in = ST_DIVV;
               end
            end
         end
         ST_DIVM: begin
            acc_in = acc_step;
            quo_in = quo_step;
            dvd_in = {dvd_ff[DW-2:0], 1'b0};
            cnt_in = cnt_ff - 1'b1;
            if (step_last) begin
               // mean done; start n*Q
               mean_in  = quo_step[OW-1:0];
               acc_in   = '0;
               mcand_in = AW'(sq_ff);
               mpl_in   = MW'(n_ff);
               cnt_in   = SW'(sms_pkg::MNQ_STEPS);
               state_in = ST_MNQ;
            end
         end
         ST_DIVV: begin
            acc_in = acc_step;
            quo_in = quo_step;
            dvd_in = {dvd_ff[DW-2:0], 1'b0};
            cnt_in = cnt_ff - 1'b1;
            if (step_last) begin
               // variance done; start the root
               dvd_in   = {quo_step, {(DW - QW){1'b0}}};
               acc_in   = '0;
               quo_in   = '0;
               cnt_in   = SW'(sms_pkg::SQRT_STEPS);
               state_in = ST_SQRT;
            end
         end
         ST_SQRT: begin
            acc_in = acc_step;
            quo_in = quo_step;
            dvd_in = {dvd_ff[DW-3:0], 2'b00};
            cnt_in = cnt_ff - 1'b1;
            if (step_last) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // hold until the output register is free, then clear the run
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_mean_in  = mean_ff;
               rsp_sd_in    = quo_ff[OW-1:0];
               sum_in       = '0;
               sq_in        = '0;
               taken_in     = '0;
               warm_in      = 1'b0;
               state_in     = ST_IDLE;
            end
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         warm_ff      <= 1'b0;
         taken_ff     <= '0;
         sum_ff       <= '0;
         sq_ff        <= '0;
         count_ff     <= sms_pkg::COUNT_RESET;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         warm_ff      <= warm_in;
         taken_ff     <= taken_in;
         sum_ff       <= sum_in;
         sq_ff        <= sq_in;
         count_ff     <= count_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      n_ff        <= n_in;
      den_ff      <= den_in;
      acc_ff      <= acc_in;
      mcand_ff    <= mcand_in;
      mpl_ff      <= mpl_in;
      dvd_ff      <= dvd_in;
      quo_ff      <= quo_in;
      mean_ff     <= mean_in;
      rsp_mean_ff <= rsp_mean_in;
      rsp_sd_ff   <= rsp_sd_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_mean_q8   = rsp_mean_ff;
   assign rsp_stddev_q8 = rsp_sd_ff;

   // The final sample of a run starts the sequencer
   a_final_starts: assert property (@(posedge clock) disable iff (reset)
      (req_fire && warm_ff && last_sample) |=> (state_ff == ST_MD))
      else $error("final sample did not start the sequencer");

   // Subtracting S*S from n*Q never borrows
   a_dev_no_borrow: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MSS && mpl_ff[0]) |-> alu_carry)
      else $error("deviation went negative");

   // A result word appears only out of the load state
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_DONE))
      else $error("result word loaded outside the load state");

endmodule

`default_nettype wire

// ----- dv/tb_sample_mean_stddev_core.sv -----
// Self-checking testbench for sample_mean_stddev_core: directed runs, then random phases.
// Each phase sets a sample count and streams words; a predictor checks mean and stddev.
// Depends on sms_pkg and sample_mean_stddev_core.
`timescale 1ns / 1ps

module tb_sample_mean_stddev_core;

   localparam int IN_W           = sms_pkg::IN_W;
   localparam int OUT_W          = sms_pkg::OUT_W;
   localparam int CNT_W          = sms_pkg::CNT_W;
   localparam int COUNT_MAX      = 4095;
   localparam int SAMPLE_W       = 16;
   localparam int HALF_PERIOD    = 5;
   localparam int SETTLE_CYCLES  = 256;        // covers the stats pass
   localparam int CYCLE_LIMIT    = 1_000_000;
   localparam int RANDOM_SAMPLES = 1200;
   localparam int RANDOM_RUNS    = 48;

   typedef struct packed {
      logic [OUT_W-1:0] mean_q8;
      logic [OUT_W-1:0] stddev_q8;
   } stats_type;

   typedef enum logic {STEP_WRITE, STEP_WORD} step_kind_type;

   typedef struct {
      step_kind_type    kind;
      logic [IN_W-1:0]  value;
      int               reps;
      bit               typed;
      stats_type        want;
   } dir_step_type;

   typedef enum logic [1:0] {MIX_FULL, MIX_NEAR, MIX_EDGE} mix_type;

   logic              clock = 1'b0;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   logic [IN_W-1:0]   req_sample;
   logic              rsp_valid;
   logic              rsp_ready;
   logic [OUT_W-1:0]  rsp_mean_q8;
   logic [OUT_W-1:0]  rsp_stddev_q8;
   logic              csr_wr_en;
   logic [CNT_W-1:0]  csr_wr_data;

   // Mirror of the run state
   logic [CNT_W-1:0]  m_count;
   logic [27:0]       m_sum;
   logic [43:0]       m_sq;
   logic [CNT_W-1:0]  m_taken;
   bit                m_warm;

   stats_type         pending_stats [$];
   stats_type         got_stats;
   int                failures = 0;
   int                cycles = 0;
   int                samples_accumulated = 0;
   int                stats_issued = 0;
   bit                tx_calm = 1'b0;
   bit                rx_calm = 1'b0;
   dir_step_type      directed_steps [8];

   sample_mean_stddev_core #(
      .MAX_COUNT   (COUNT_MAX),
      .SAMPLE_BITS (SAMPLE_W)
   ) dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_sample    (req_sample),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_mean_q8   (rsp_mean_q8),
      .rsp_stddev_q8 (rsp_stddev_q8),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data)
   );

   always #(HALF_PERIOD) clock = ~clock;

   // Clamp the programmed count to the legal run length
   function automatic int eff_count(logic [CNT_W-1:0] c);
      int k;
      k = int'(c);
      if (k < int'(sms_pkg::MIN_COUNT)) k = int'(sms_pkg::MIN_COUNT);
      if (k > COUNT_MAX) k = COUNT_MAX;
      return k;
   endfunction

   function automatic void clear_run_state();
      m_sum   = '0;
      m_sq    = '0;
      m_taken = '0;
      m_warm  = 1'b0;
   endfunction

   // Fold one accepted word into the run; on the last one compute the stats
   task automatic accumulate_sample(input logic [IN_W-1:0] v, output bit done,
                                    output stats_type st);
      logic [63:0]  n;
      logic [63:0]  sum64;
      logic [63:0]  sq64;
      logic [63:0]  w64;
      logic [63:0]  dev;
      logic [63:0]  var_q16;
      logic [63:0]  root;
      logic [63:0]  trial;
      logic [63:0]  mean64;
      logic [127:0] scaled;
      done = 1'b0;
      st   = '0;
      if (!m_warm) begin
         // drop the warm-up word
         m_warm = 1'b1;
      end else begin
         w64     = 64'(v);
         m_sum   = m_sum + 28'(v);
         m_sq    = m_sq + 44'(w64 * w64);
         m_taken = m_taken + CNT_W'(1);
         samples_accumulated++;
         if (int'(m_taken) >= eff_count(m_count)) begin
            n       = 64'(m_taken);
            sum64   = 64'(m_sum);
            sq64    = 64'(m_sq);
            dev     = n * sq64 - sum64 * sum64;
            scaled  = {64'd0, dev} << 16;
            var_q16 = 64'(scaled / {64'd0, n * (n - 64'd1)});
            // bitwise integer square root, high bit first
            root = '0;
            for (int i = 31; i >= 0; i--) begin
               trial = root | (64'd1 << i);
               if (trial * trial <= var_q16) root = trial;
            end
            mean64       = (sum64 << 8) / n;
            st.mean_q8   = mean64[OUT_W-1:0];
            st.stddev_q8 = root[OUT_W-1:0];
            done = 1'b1;
            clear_run_state();
         end
      end
   endtask

   // Present one word after a random gap and hold it until accepted
   task automatic send_word(input logic [IN_W-1:0] v, input bit typed,
                            input stats_type want);
      int        gap;
      bit        done;
      stats_type st;
      gap = tx_calm ? 0 : $urandom_range(0, 15);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid  <= 1'b1;
      req_sample <= v;
      do @(posedge clock); while (!req_ready);
      accumulate_sample(v, done, st);
      if (done) begin
         pending_stats.push_back(typed ? want : st);
         stats_issued++;
      end
      @(negedge clock);
   endtask

   // Program the count only once the core has drained and settled
   task automatic write_sample_count(input logic [CNT_W-1:0] v);
      req_valid <= 1'b0;
      while (pending_stats.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      m_count = v;
   endtask

   function automatic logic [IN_W-1:0] draw_word(mix_type mix, logic [IN_W-1:0] center);
      logic [IN_W-1:0] w;
      w = IN_W'($urandom);
      if ($urandom_range(0, 7) == 0) mix = MIX_FULL;
      case (mix)
         MIX_NEAR: begin
            w = {center[IN_W-1:6], w[5:0]};
         end
         MIX_EDGE: begin
            w = {IN_W{w[0]}};
         end
         default: begin
         end
      endcase
      return w;
   endfunction

   // Stall the result side at random before each word
   initial begin
      int stall;
      rsp_ready = 1'b0;
      @(negedge clock);
      forever begin
         stall = rx_calm ? 0 : $urandom_range(0, 15);
         if (stall != 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (reset || !(rsp_valid && rsp_ready));
         @(negedge clock);
      end
   end

   // Compare each result word with the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_stats.size() == 0) begin
            $error("unexpected result: mean_q8 %0d stddev_q8 %0d",
                   rsp_mean_q8, rsp_stddev_q8);
            failures++;
         end else begin
            got_stats = pending_stats.pop_front();
            if (rsp_mean_q8 !== got_stats.mean_q8) begin
               $error("mean_q8: expected %0d, got %0d", got_stats.mean_q8, rsp_mean_q8);
               failures++;
            end
            if (rsp_stddev_q8 !== got_stats.stddev_q8) begin
               $error("stddev_q8: expected %0d, got %0d",
                      got_stats.stddev_q8, rsp_stddev_q8);
               failures++;
            end
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   initial begin
      int              k;
      int              keff;
      int              n_items;
      logic [IN_W-1:0] center;
      mix_type         mix;
      stats_type       none;

      none        = '0;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_sample  = '0;
      csr_wr_en   = 1'b0;
      csr_wr_data = '0;
      m_count     = sms_pkg::COUNT_RESET;
      clear_run_state();

      // Warm-up and lowered count at the reset count, then a clamped count of zero
      directed_steps[0] = '{STEP_WORD,  16'hFFFF, 1,  1'b0, '0};
      directed_steps[1] = '{STEP_WORD,  16'hFFFF, 11, 1'b0, '0};
      directed_steps[2] = '{STEP_WRITE, 16'd10,   0,  1'b0, '0};
      directed_steps[3] = '{STEP_WORD,  16'hFFFF, 1,  1'b1,
                            stats_type'{24'd16776960, 24'd0}};
      directed_steps[4] = '{STEP_WRITE, 16'd0,    0,  1'b0, '0};
      directed_steps[5] = '{STEP_WORD,  16'h3039, 1,  1'b0, '0};
      directed_steps[6] = '{STEP_WORD,  16'd0,    9,  1'b0, '0};
      directed_steps[7] = '{STEP_WORD,  16'd0,    1,  1'b1, stats_type'{24'd0, 24'd0}};

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Walk the directed steps
      foreach (directed_steps[i]) begin
         if (directed_steps[i].kind == STEP_WRITE) begin
            write_sample_count(directed_steps[i].value[CNT_W-1:0]);
         end else begin
            repeat (directed_steps[i].reps)
               send_word(directed_steps[i].value, directed_steps[i].typed,
                         directed_steps[i].want);
         end
      end

      // Random phases: new count, then enough words to finish and start runs
      samples_accumulated = 0;
      stats_issued        = 0;
      while (samples_accumulated < RANDOM_SAMPLES || stats_issued < RANDOM_RUNS) begin
         case ($urandom_range(0, 9))
            0: k = $urandom_range(0, 9);
            1: k = $urandom_range(25, 250);
            default: k = $urandom_range(10, 24);
         endcase
         write_sample_count(k[CNT_W-1:0]);
         keff    = eff_count(m_count);
         n_items = (m_warm ? 0 : 1) +
                   ((int'(m_taken) >= keff) ? 1 : keff - int'(m_taken));
         n_items += $urandom_range(0, 2) * (keff + 1) + $urandom_range(0, keff);
         tx_calm = ($urandom_range(0, 3) == 0);
         rx_calm = ($urandom_range(0, 3) == 0);
         center  = IN_W'($urandom);
         case ($urandom_range(0, 2))
            0: mix = MIX_FULL;
            1: mix = MIX_NEAR;
            default: mix = MIX_EDGE;
         endcase
         repeat (n_items) send_word(draw_word(mix, center), 1'b0, none);
      end

      // Drain, settle, report
      req_valid <= 1'b0;
      while (pending_stats.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (failures == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
hdl/sms_pkg.sv
hdl/sample_mean_stddev_core.sv
dv/tb_sample_mean_stddev_core.sv
